[rtl/mcca_pkg.sv]
// ----------------------------------------------------------------------------
// Masked complex cell averager package
// Shared types, command codes and status codes.
// ----------------------------------------------------------------------------
package mcca_pkg;

  localparam int SampleW = 16;
  localparam int CountW  = 11;
  localparam int RegW    = 7;

  localparam logic CMD_ACCUMULATE = 1'b0;
  localparam logic CMD_READ       = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_SATURATED = 2'd2;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch the input item and read the cell
    logic clear_cell; // treat the cell as empty
    logic sqrt_start; // start a square root
    logic sqrt_sel;   // 0: sample magnitude, 1: magnitude of mean
    logic div_start;  // start the three divisions
    logic write_cell; // write the accumulated cell back
    logic emit;       // load the output register
    logic emit_range; // result is an out-of-range result
    logic emit_sat;   // result carries saturated status
  } mcca_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic        sqrt_done;
    logic        div_done;
    logic        out_busy;
    logic [10:0] cell_count; // count of the cell that was just read
  } mcca_stat_t;

endpackage

[rtl/mcca_if.sv]
// ----------------------------------------------------------------------------
// Masked complex cell averager channels
// Valid/ready interfaces for the input, output and configuration channels.
// ----------------------------------------------------------------------------
interface mcca_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [5:0]  row;
  logic [5:0]  col;
  logic signed [15:0] sample_re;
  logic signed [15:0] sample_im;
  logic        sample_missing;
  logic        first_example;
  modport source (output valid, command, row, col, sample_re, sample_im,
                  sample_missing, first_example, input ready);
  modport sink (input valid, command, row, col, sample_re, sample_im,
                sample_missing, first_example, output ready);
endinterface

interface mcca_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] avg_re;
  logic signed [15:0] avg_im;
  logic [15:0] avg_magnitude;
  logic [15:0] magnitude_of_avg;
  logic [10:0] sample_count;
  logic        no_data;
  logic [1:0]  status;
  modport source (output valid, avg_re, avg_im, avg_magnitude, magnitude_of_avg,
                  sample_count, no_data, status, input ready);
  modport sink (input valid, avg_re, avg_im, avg_magnitude, magnitude_of_avg,
                sample_count, no_data, status, output ready);
endinterface

interface mcca_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [6:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/masked_complex_cell_averager_unit.sv]
// ----------------------------------------------------------------------------
// Masked complex cell averager
// Per-cell complex sums and counts with read-out of means and magnitudes.
// A present accumulate runs the 16-step square root; a read or a saturated
// accumulate runs the 26-step divider and then the square root; a missing
// sample or an out-of-range cell uses neither. A result still waiting at the
// output holds the next result-bearing item in its last state.
// Throughput: one item at a time. Reset returns the registers to 64 and 64;
// cell contents are undefined until a cell is restarted with first_example.
// ----------------------------------------------------------------------------
module masked_complex_cell_averager_unit #(
  parameter int MAX_ROWS     = 64,
  parameter int MAX_COLS     = 64,
  parameter int MAX_EXAMPLES = 1024
) (
  input logic clk,
  input logic rst,
  mcca_in_if.sink    in_ch,
  mcca_out_if.source out_ch,
  mcca_cfg_if.sink   cfg
);
  import mcca_pkg::*;

  logic [6:0] rows_in_use;
  logic [6:0] cols_in_use;
  mcca_cmd_t  cmd;
  mcca_stat_t stat;

  // Configuration registers.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 7'd64;
      cols_in_use <= 7'd64;
    end else if (cfg.valid) begin
      if (cfg.index == REG_ROWS) rows_in_use <= cfg.data;
      else cols_in_use <= cfg.data;
    end
  end

  mcca_ctrl #(.MaxRows(MAX_ROWS), .MaxCols(MAX_COLS), .MaxExamples(MAX_EXAMPLES)) u_ctrl (
    .clk(clk), .rst(rst), .rows_in_use(rows_in_use), .cols_in_use(cols_in_use),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_command(in_ch.command),
    .in_row(in_ch.row), .in_col(in_ch.col), .in_missing(in_ch.sample_missing),
    .in_first(in_ch.first_example), .cmd(cmd), .stat(stat)
  );

  mcca_datapath #(.MaxRows(MAX_ROWS), .MaxCols(MAX_COLS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .in_ch(in_ch), .out_ch(out_ch)
  );
endmodule

[rtl/mcca_isqrt.sv]
// ----------------------------------------------------------------------------
// Iterative integer square root
// Floored square root of a 32-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module mcca_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] radicand,
  output logic        done,
  output logic [15:0] root
);
  logic [31:0] rem;
  logic [31:0] res;
  logic [31:0] bitv;
  logic        busy;
  logic [31:0] trial;

  assign trial = res + bitv;
  assign root  = res[15:0];

  // Classic digit-by-digit method, one pair of radicand bits a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= radicand;
        res  <= '0;
        bitv <= 32'h4000_0000;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[rtl/mcca_divider.sv]
// ----------------------------------------------------------------------------
// Three-lane restoring divider
// Divides the three cell sums by the count, truncating toward zero.
// ----------------------------------------------------------------------------
module mcca_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [25:0] num_re,
  input  logic signed [25:0] num_im,
  input  logic [25:0]        num_mag,
  input  logic [10:0]        divisor,
  output logic               done,
  output logic signed [15:0] q_re,
  output logic signed [15:0] q_im,
  output logic [15:0]        q_mag
);
  logic [25:0] a_re, a_im, a_mag;
  logic [10:0] r_re, r_im, r_mag;
  logic [10:0] dv;
  logic        neg_re, neg_im;
  logic [4:0]  cnt;
  logic        busy;
  logic [11:0] t_re, t_im, t_mag;

  // Shift in the next numerator bit of each lane.
  assign t_re  = {r_re, a_re[25]};
  assign t_im  = {r_im, a_im[25]};
  assign t_mag = {r_mag, a_mag[25]};

  assign q_re  = neg_re ? -$signed(a_re[15:0]) : $signed(a_re[15:0]);
  assign q_im  = neg_im ? -$signed(a_im[15:0]) : $signed(a_im[15:0]);
  assign q_mag = a_mag[15:0];

  // One quotient bit per lane each cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_re   <= num_re[25] ? 26'(-num_re) : num_re;
        a_im   <= num_im[25] ? 26'(-num_im) : num_im;
        a_mag  <= num_mag;
        neg_re <= num_re[25];
        neg_im <= num_im[25];
        r_re   <= '0;
        r_im   <= '0;
        r_mag  <= '0;
        dv     <= divisor;
        cnt    <= 5'd25;
        busy   <= 1'b1;
      end else if (busy) begin
        if (t_re >= {1'b0, dv}) begin
          r_re <= 11'(t_re - {1'b0, dv});
          a_re <= {a_re[24:0], 1'b1};
        end else begin
          r_re <= t_re[10:0];
          a_re <= {a_re[24:0], 1'b0};
        end
        if (t_im >= {1'b0, dv}) begin
          r_im <= 11'(t_im - {1'b0, dv});
          a_im <= {a_im[24:0], 1'b1};
        end else begin
          r_im <= t_im[10:0];
          a_im <= {a_im[24:0], 1'b0};
        end
        if (t_mag >= {1'b0, dv}) begin
          r_mag <= 11'(t_mag - {1'b0, dv});
          a_mag <= {a_mag[24:0], 1'b1};
        end else begin
          r_mag <= t_mag[10:0];
          a_mag <= {a_mag[24:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[rtl/mcca_datapath.sv]
// ----------------------------------------------------------------------------
// Masked complex cell averager datapath
// Cell memory, input latch, square root and divider units, output register.
// ----------------------------------------------------------------------------
module mcca_datapath #(
  parameter int MaxRows = 64,
  parameter int MaxCols = 64
) (
  input  logic clk,
  input  logic rst,
  input  mcca_pkg::mcca_cmd_t  cmd,
  output mcca_pkg::mcca_stat_t stat,
  mcca_in_if.sink   in_ch,
  mcca_out_if.source out_ch
);
  import mcca_pkg::*;

  localparam int Cells = MaxRows * MaxCols;
  localparam int AddrW = $clog2(Cells);

  logic signed [25:0] mem_re  [Cells];
  logic signed [25:0] mem_im  [Cells];
  logic [25:0]        mem_mag [Cells];
  logic [10:0]        mem_cnt [Cells];

  logic [AddrW-1:0]   addr;
  logic signed [15:0] s_re, s_im;
  logic signed [25:0] c_re, c_im;
  logic [25:0]        c_mag;
  logic [10:0]        c_cnt;
  logic [15:0]        smag;
  logic [31:0]        sq_in;
  logic [31:0]        mul_re, mul_im;
  logic               sq_done, dv_done;
  logic [15:0]        sq_root;
  logic signed [15:0] q_re, q_im;
  logic [15:0]        q_mag;

  // Latch the item and read the cell (read data registered).
  // Clearing a cell also clears its memory entry, so a restart with a
  // missing sample leaves the cell empty.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr  <= AddrW'(32'(in_ch.row) * 32'(MaxCols) + 32'(in_ch.col));
      s_re  <= in_ch.sample_re;
      s_im  <= in_ch.sample_im;
      c_re  <= mem_re[AddrW'(32'(in_ch.row) * 32'(MaxCols) + 32'(in_ch.col))];
      c_im  <= mem_im[AddrW'(32'(in_ch.row) * 32'(MaxCols) + 32'(in_ch.col))];
      c_mag <= mem_mag[AddrW'(32'(in_ch.row) * 32'(MaxCols) + 32'(in_ch.col))];
      c_cnt <= mem_cnt[AddrW'(32'(in_ch.row) * 32'(MaxCols) + 32'(in_ch.col))];
    end else if (cmd.clear_cell) begin
      c_re  <= '0;
      c_im  <= '0;
      c_mag <= '0;
      c_cnt <= '0;
      mem_re[addr]  <= '0;
      mem_im[addr]  <= '0;
      mem_mag[addr] <= '0;
      mem_cnt[addr] <= '0;
    end else if (cmd.write_cell) begin
      mem_re[addr]  <= c_re + 26'(s_re);
      mem_im[addr]  <= c_im + 26'(s_im);
      mem_mag[addr] <= c_mag + 26'(smag);
      mem_cnt[addr] <= c_cnt + 11'd1;
    end
  end

  // Squares are registered ahead of the square root.
  always_ff @(posedge clk) begin
    if (cmd.sqrt_sel) begin
      mul_re <= 32'($signed(q_re) * $signed(q_re));
      mul_im <= 32'($signed(q_im) * $signed(q_im));
    end else begin
      mul_re <= 32'($signed(s_re) * $signed(s_re));
      mul_im <= 32'($signed(s_im) * $signed(s_im));
    end
  end
  assign sq_in = mul_re + mul_im;

  mcca_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(cmd.sqrt_start), .radicand(sq_in),
    .done(sq_done), .root(sq_root)
  );

  always_ff @(posedge clk) begin
    if (sq_done && !cmd.sqrt_sel) smag <= sq_root;
  end

  mcca_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num_re(c_re), .num_im(c_im),
    .num_mag(c_mag), .divisor(c_cnt), .done(dv_done), .q_re(q_re), .q_im(q_im),
    .q_mag(q_mag)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.emit) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.valid && out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.emit_range || c_cnt == 11'd0) begin
        out_ch.avg_re           <= '0;
        out_ch.avg_im           <= '0;
        out_ch.avg_magnitude    <= '0;
        out_ch.magnitude_of_avg <= '0;
        out_ch.sample_count     <= '0;
        out_ch.no_data          <= 1'b1;
      end else begin
        out_ch.avg_re           <= q_re;
        out_ch.avg_im           <= q_im;
        out_ch.avg_magnitude    <= q_mag;
        out_ch.magnitude_of_avg <= sq_root;
        out_ch.sample_count     <= c_cnt;
        out_ch.no_data          <= 1'b0;
      end
      out_ch.status <= cmd.emit_range ? ST_RANGE : (cmd.emit_sat ? ST_SATURATED : ST_OK);
    end
  end

  assign stat.sqrt_done  = sq_done;
  assign stat.div_done   = dv_done;
  assign stat.out_busy   = out_ch.valid;
  assign stat.cell_count = c_cnt;
endmodule

[rtl/mcca_ctrl.sv]
// ----------------------------------------------------------------------------
// Masked complex cell averager controller
// Sequences each item through the cell read, square root and divider.
// ----------------------------------------------------------------------------
module mcca_ctrl #(
  parameter int MaxRows     = 64,
  parameter int MaxCols     = 64,
  parameter int MaxExamples = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic [6:0] rows_in_use,
  input  logic [6:0] cols_in_use,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_command,
  input  logic [5:0] in_row,
  input  logic [5:0] in_col,
  input  logic       in_missing,
  input  logic       in_first,
  output mcca_pkg::mcca_cmd_t cmd,
  input  mcca_pkg::mcca_stat_t stat
);
  import mcca_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_MAGSQ = 3'd2;
  localparam logic [2:0] S_MAGW  = 3'd3;
  localparam logic [2:0] S_DIVW  = 3'd4;
  localparam logic [2:0] S_AVGSQ = 3'd5;
  localparam logic [2:0] S_AVGW  = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0] state, state_next;
  logic       op_read, op_first, op_missing, op_range, op_sat;
  logic       op_read_next, op_first_next, op_missing_next, op_range_next;
  logic       op_sat_next;
  logic       in_range;

  assign in_range = ({1'b0, in_row} < rows_in_use) && ({1'b0, in_col} < cols_in_use) &&
                    (32'(in_row) < MaxRows) && (32'(in_col) < MaxCols);
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      op_read    <= 1'b0;
      op_first   <= 1'b0;
      op_missing <= 1'b0;
      op_range   <= 1'b0;
      op_sat     <= 1'b0;
    end else begin
      state      <= state_next;
      op_read    <= op_read_next;
      op_first   <= op_first_next;
      op_missing <= op_missing_next;
      op_range   <= op_range_next;
      op_sat     <= op_sat_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next      = state;
    op_read_next    = op_read;
    op_first_next   = op_first;
    op_missing_next = op_missing;
    op_range_next   = op_range;
    op_sat_next     = op_sat;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load        = 1'b1;
          op_read_next    = (in_command == CMD_READ);
          op_first_next   = in_first;
          op_missing_next = in_missing;
          op_range_next   = !in_range;
          op_sat_next     = 1'b0;
          state_next      = S_LOOK;
        end
      end
      S_LOOK: begin
        if (op_range) begin
          state_next = S_EMIT;
        end else if (op_read) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIVW;
        end else begin
          cmd.clear_cell = op_first;
          if (op_missing) begin
            state_next = S_IDLE;
            cmd.write_cell = 1'b0;
          end else if (!op_first && 32'(stat.cell_count) >= MaxExamples) begin
            op_sat_next   = 1'b1;
            cmd.div_start = 1'b1;
            state_next    = S_DIVW;
          end else begin
            state_next = S_MAGSQ;
          end
        end
      end
      S_MAGSQ: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_MAGW;
      end
      S_MAGW: begin
        if (stat.sqrt_done) state_next = S_EMIT;
      end
      S_DIVW: begin
        // The squares of the quotients are registered as the divider finishes.
        cmd.sqrt_sel = 1'b1;
        if (stat.div_done) state_next = S_AVGSQ;
      end
      S_AVGSQ: begin
        cmd.sqrt_sel   = 1'b1;
        cmd.sqrt_start = 1'b1;
        state_next     = S_AVGW;
      end
      S_AVGW: begin
        cmd.sqrt_sel = 1'b1;
        if (stat.sqrt_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.sqrt_sel = op_read || op_sat;
        if (!op_read && !op_sat && !op_range) begin
          cmd.write_cell = 1'b1;
          state_next     = S_IDLE;
        end else if (!stat.out_busy) begin
          cmd.emit       = 1'b1;
          cmd.emit_range = op_range;
          cmd.emit_sat   = op_sat;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
